FILE: hdl/cats_pkg.sv
// Shared types, constants and tables of the angle, depth and energy sampler.
`default_nettype none
package cats_pkg;

  localparam int ZENITH_BINS_DEF  = 90;
  localparam int AZIMUTH_BINS_DEF = 360;
  localparam int ENERGY_BINS_DEF  = 121;
  localparam int DEPTH_BINS_DEF   = 62;
  localparam int COS_BINS_DEF     = 51;

  localparam int QUEUE_DEPTH  = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int CORDIC_GAIN  = 652032874;
  localparam int DEG_Q16      = 65536;

  localparam logic [1:0] REG_THETA_START = 2'd0;
  localparam logic [1:0] REG_PHI_START   = 2'd1;
  localparam logic [1:0] REG_ROCK_DENS   = 2'd2;

  localparam logic [8:0] ROCK_DENS_RESET = 9'd270;

  typedef enum logic [1:0] {
    OP_SAMPLE    = 2'd0,
    OP_WR_ANGLE  = 2'd1,
    OP_WR_DEPTH  = 2'd2,
    OP_WR_ENERGY = 2'd3
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        wr_ok;
    logic [18:0] table_index;
    logic [31:0] table_value;
    logic [31:0] rand_bin;
    logic [31:0] rand_theta;
    logic [31:0] rand_phi;
    logic [31:0] rand_energy;
    logic [31:0] rand_log;
  } word_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } head_t;

  typedef struct packed {
    logic [6:0] theta_start;
    logic [8:0] phi_start;
    logic [8:0] rock_density_centi;
  } cfg_t;

  function automatic logic [21:0] cordic_atan(input logic [3:0] k);
    logic [21:0] v;
    case (k)
      4'd0:    v = 22'd2949120;
      4'd1:    v = 22'd1740967;
      4'd2:    v = 22'd919879;
      4'd3:    v = 22'd466945;
      4'd4:    v = 22'd234379;
      4'd5:    v = 22'd117304;
      4'd6:    v = 22'd58666;
      4'd7:    v = 22'd29334;
      4'd8:    v = 22'd14668;
      4'd9:    v = 22'd7334;
      4'd10:   v = 22'd3667;
      4'd11:   v = 22'd1833;
      4'd12:   v = 22'd917;
      4'd13:   v = 22'd458;
      4'd14:   v = 22'd229;
      default: v = 22'd115;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/cats_item_if.sv
// Input channel carrying sample and table write words.
`default_nettype none
interface cats_item_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [18:0] table_index;
  logic [31:0] table_value;
  logic [31:0] rand_bin;
  logic [31:0] rand_theta;
  logic [31:0] rand_phi;
  logic [31:0] rand_energy;
  logic [31:0] rand_log;

  modport source (output valid, req_type, table_index, table_value, rand_bin, rand_theta,
                  rand_phi, rand_energy, rand_log, input ready);
  modport sink (input valid, req_type, table_index, table_value, rand_bin, rand_theta,
                rand_phi, rand_energy, rand_log, output ready);
endinterface
`default_nettype wire

FILE: hdl/cats_result_if.sv
// Output channel carrying one sampled direction, depth and energy word.
`default_nettype none
interface cats_result_if;
  logic               valid;
  logic               ready;
  logic [23:0]        theta_deg;
  logic [25:0]        phi_deg;
  logic [14:0]        depth_mwe;
  logic signed [19:0] log_energy;

  modport source (output valid, theta_deg, phi_deg, depth_mwe, log_energy, input ready);
  modport sink (input valid, theta_deg, phi_deg, depth_mwe, log_energy, output ready);
endinterface
`default_nettype wire

FILE: hdl/cats_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module cats_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

FILE: hdl/cats_front.sv
// Front end: accepts input words, classifies them and queues them for the back end.
`default_nettype none
module cats_front import cats_pkg::*; #(
  parameter int ZENITH_BINS  = ZENITH_BINS_DEF,
  parameter int AZIMUTH_BINS = AZIMUTH_BINS_DEF,
  parameter int ENERGY_BINS  = ENERGY_BINS_DEF,
  parameter int DEPTH_BINS   = DEPTH_BINS_DEF,
  parameter int COS_BINS     = COS_BINS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  cats_item_if.sink   item,
  output head_t       head,
  input  wire logic   pop
);

  localparam int ANG_SIZE = ZENITH_BINS * AZIMUTH_BINS + 1;
  localparam int DEP_SIZE = (ZENITH_BINS + 1) * AZIMUTH_BINS;
  localparam int EN_SIZE  = COS_BINS * DEPTH_BINS * ENERGY_BINS;
  localparam int QW       = $clog2(QUEUE_DEPTH);

  word_t        queue [QUEUE_DEPTH];
  logic [QW-1:0] wr_ptr;
  logic [QW-1:0] rd_ptr;
  logic [QW:0]   count;
  logic          push;
  word_t         incoming;

  assign item.ready = (count != (QW+1)'(QUEUE_DEPTH));
  assign push       = item.valid && item.ready;

  always_comb begin
    incoming.op          = op_t'(item.req_type);
    incoming.table_index = item.table_index;
    incoming.table_value = item.table_value;
    incoming.rand_bin    = item.rand_bin;
    incoming.rand_theta  = item.rand_theta;
    incoming.rand_phi    = item.rand_phi;
    incoming.rand_energy = item.rand_energy;
    incoming.rand_log    = item.rand_log;
    case (incoming.op)
      OP_WR_ANGLE:  incoming.wr_ok = 32'(item.table_index) < 32'(ANG_SIZE);
      OP_WR_DEPTH:  incoming.wr_ok = 32'(item.table_index) < 32'(DEP_SIZE);
      OP_WR_ENERGY: incoming.wr_ok = 32'(item.table_index) < 32'(EN_SIZE);
      default:      incoming.wr_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  assign head.valid = (count != '0);
  assign head.word  = queue[rd_ptr];

endmodule
`default_nettype wire

FILE: hdl/cats_back.sv
// Back end: performs table writes and runs the scans, depth scaling, CORDIC and log step.
`default_nettype none
module cats_back import cats_pkg::*; #(
  parameter int ZENITH_BINS  = ZENITH_BINS_DEF,
  parameter int AZIMUTH_BINS = AZIMUTH_BINS_DEF,
  parameter int ENERGY_BINS  = ENERGY_BINS_DEF,
  parameter int DEPTH_BINS   = DEPTH_BINS_DEF,
  parameter int COS_BINS     = COS_BINS_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  cfg_t        cfg,
  input  head_t       head,
  output logic        pop,
  cats_result_if.source result
);

  localparam int LAST     = ZENITH_BINS * AZIMUTH_BINS;
  localparam int ANG_SIZE = LAST + 1;
  localparam int DEP_SIZE = (ZENITH_BINS + 1) * AZIMUTH_BINS;
  localparam int EN_SIZE  = COS_BINS * DEPTH_BINS * ENERGY_BINS;
  localparam int AWA      = (ANG_SIZE > 1) ? $clog2(ANG_SIZE) : 1;
  localparam int AWD      = (DEP_SIZE > 1) ? $clog2(DEP_SIZE) : 1;
  localparam int AWE      = (EN_SIZE > 1) ? $clog2(EN_SIZE) : 1;
  localparam int TBW      = (ZENITH_BINS > 1) ? $clog2(ZENITH_BINS) : 1;
  localparam int PBW      = (AZIMUTH_BINS > 1) ? $clog2(AZIMUTH_BINS) : 1;
  localparam int JW       = $clog2(ENERGY_BINS);
  localparam int CBW      = $clog2(COS_BINS);
  localparam int DBW      = (DEPTH_BINS > 1) ? $clog2(DEPTH_BINS) : 1;
  localparam int THW      = ((TBW > 7) ? TBW : 7) + 1;
  localparam int PHW      = ((PBW > 9) ? PBW : 9) + 1;
  localparam int UW       = JW + 15;
  localparam int KW       = $clog2(CORDIC_STEPS);
  localparam longint RM   = (64'd1 << 35) / 1000;
  localparam longint RQ   = (64'd1 << 40) / 200000;
  localparam longint R5   = (64'd1 << 26) / 5;

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_ASCAN = 17'h00002,
    S_DREAD = 17'h00004,
    S_DMUL  = 17'h00008,
    S_DEST  = 17'h00010,
    S_DCHK  = 17'h00020,
    S_DFIX  = 17'h00040,
    S_CORD  = 17'h00080,
    S_CBIN  = 17'h00100,
    S_EROW  = 17'h00200,
    S_EBASE = 17'h00400,
    S_ESCAN = 17'h00800,
    S_LOG1  = 17'h01000,
    S_LOG2  = 17'h02000,
    S_LOG3  = 17'h04000,
    S_LOG4  = 17'h08000,
    S_OUT   = 17'h10000
  } state_t;

  state_t state;
  word_t  cur;

  logic [AWA-1:0] a;
  logic [TBW-1:0] ctb;
  logic [PBW-1:0] cpb;
  logic           d_valid;
  logic [AWA-1:0] d_idx;
  logic [TBW-1:0] d_tb;
  logic [PBW-1:0] d_pb;
  logic [AWA-1:0] cidx;
  logic [TBW-1:0] tb;
  logic [PBW-1:0] pb;

  logic [THW+15:0] theta;
  logic [PHW+15:0] phi;
  logic [24:0]     prod;
  logic [15:0]     est_m;
  logic [7:0]      est_q;
  logic [24:0]     rem_m;
  logic [24:0]     rem_q;
  logic [14:0]     mwe;
  logic [DBW-1:0]  db;

  logic signed [33:0] x;
  logic signed [33:0] y;
  logic signed [25:0] z;
  logic [KW-1:0]      k;
  logic               cz;
  logic [CBW-1:0]     cb;

  logic [AWE-1:0] erow;
  logic [AWE-1:0] ea;
  logic [JW-1:0]  ej;
  logic           ed_valid;
  logic [JW-1:0]  ed_j;
  logic [JW-1:0]  jf;

  logic [UW-1:0] u;
  logic [UW-3:0] qe;
  logic [UW-1:0] ru;
  logic [19:0]   lg;

  logic        rvalid;
  logic [23:0] out_theta;
  logic [25:0] out_phi;
  logic [14:0] out_mwe;
  logic [19:0] out_lg;

  logic            ang_we, dep_we, en_we;
  logic            ang_re, dep_re, en_re;
  logic [31:0]     ang_rdata;
  logic [15:0]     dep_rdata;
  logic [31:0]     en_rdata;
  logic            ang_hit, en_hit;

  logic [50:0] pm;
  logic [47:0] pq;
  logic [15:0] m_fix;
  logic [7:0]  q_fix;
  logic [25:0] t26;
  logic [40:0] cbp;
  logic [10:0] cbv;
  logic [UW+23:0] p5;
  logic [UW-3:0]  q5;
  logic           out_free;
  logic signed [33:0] ysh, xsh;
  logic signed [25:0] at;

  assign pop    = (state == S_IDLE) && head.valid;
  assign ang_we = pop && head.word.op == OP_WR_ANGLE && head.word.wr_ok;
  assign dep_we = pop && head.word.op == OP_WR_DEPTH && head.word.wr_ok;
  assign en_we  = pop && head.word.op == OP_WR_ENERGY && head.word.wr_ok;
  assign ang_re = (state == S_ASCAN);
  assign dep_re = (state == S_DREAD);
  assign en_re  = (state == S_ESCAN);

  cats_ram #(.WIDTH(32), .DEPTH(ANG_SIZE)) u_angle_cdf (
    .clk   (clk),
    .we    (ang_we),
    .waddr (AWA'(head.word.table_index)),
    .wdata (head.word.table_value),
    .re    (ang_re),
    .raddr (a),
    .rdata (ang_rdata)
  );

  cats_ram #(.WIDTH(16), .DEPTH(DEP_SIZE)) u_depth_map (
    .clk   (clk),
    .we    (dep_we),
    .waddr (AWD'(head.word.table_index)),
    .wdata (head.word.table_value[15:0]),
    .re    (dep_re),
    .raddr (AWD'(cidx)),
    .rdata (dep_rdata)
  );

  cats_ram #(.WIDTH(32), .DEPTH(EN_SIZE)) u_energy_cdf (
    .clk   (clk),
    .we    (en_we),
    .waddr (AWE'(head.word.table_index)),
    .wdata (head.word.table_value),
    .re    (en_re),
    .raddr (ea),
    .rdata (en_rdata)
  );

  always_comb begin
    ang_hit = d_valid && (cur.rand_bin <= ang_rdata || d_idx == AWA'(LAST));
    en_hit  = ed_valid && (cur.rand_energy <= en_rdata || ed_j == JW'(ENERGY_BINS - 1));
    pm      = 51'(prod) * 51'(RM);
    pq      = 48'(prod) * 48'(RQ);
    m_fix   = est_m + 16'(rem_m >= 25'd1000);
    q_fix   = est_q + 8'(rem_q >= 25'd200000);
    t26     = 26'(theta);
    if (t26 > 26'(180 * DEG_Q16)) begin
      t26 = 26'(360 * DEG_Q16) - t26;
    end
    ysh     = y >>> k;
    xsh     = x >>> k;
    at      = $signed({4'b0, cordic_atan(4'(k))});
    cbp     = 41'(x[32:0]) * 41'(COS_BINS - 1);
    cbv     = cbp[40:30];
    p5      = (UW+24)'(u) * (UW+24)'(R5);
    q5      = qe + (UW-2)'(ru >= UW'(5));
    lg      = 20'(q5) - 20'd4096;
    out_free = !rvalid || result.ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      d_valid  <= 1'b0;
      ed_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (pop && head.word.op == OP_SAMPLE) begin
            cur     <= head.word;
            a       <= AWA'(1);
            ctb     <= '0;
            cpb     <= '0;
            d_valid <= 1'b0;
            state   <= S_ASCAN;
          end
        end
        S_ASCAN: begin
          d_valid <= 1'b1;
          d_idx   <= a;
          d_tb    <= ctb;
          d_pb    <= cpb;
          if (a != AWA'(LAST)) begin
            a <= a + 1'b1;
            if (cpb == PBW'(AZIMUTH_BINS - 1)) begin
              cpb <= '0;
              ctb <= ctb + 1'b1;
            end else begin
              cpb <= cpb + 1'b1;
            end
          end
          if (ang_hit) begin
            tb    <= d_tb;
            pb    <= d_pb;
            cidx  <= d_idx - 1'b1;
            state <= S_DREAD;
          end
        end
        S_DREAD: begin
          theta <= {(THW)'(cfg.theta_start) + (THW)'(tb), cur.rand_theta[31:16]};
          phi   <= {(PHW)'(cfg.phi_start) + (PHW)'(pb), cur.rand_phi[31:16]};
          state <= S_DMUL;
        end
        S_DMUL: begin
          prod  <= 25'(dep_rdata) * 25'(cfg.rock_density_centi);
          state <= S_DEST;
        end
        S_DEST: begin
          est_m <= pm[50:35];
          est_q <= pq[47:40];
          state <= S_DCHK;
        end
        S_DCHK: begin
          rem_m <= prod - 25'(est_m * 1000);
          rem_q <= prod - 25'(est_q * 200000);
          state <= S_DFIX;
        end
        S_DFIX: begin
          mwe <= (m_fix > 16'd32767) ? 15'd32767 : m_fix[14:0];
          if (q_fix < 8'd16) begin
            db <= '0;
          end else if (32'(q_fix - 8'd16) > 32'(DEPTH_BINS - 1)) begin
            db <= DBW'(DEPTH_BINS - 1);
          end else begin
            db <= DBW'(q_fix - 8'd16);
          end
          cz    <= t26 >= 26'(90 * DEG_Q16);
          z     <= $signed(t26);
          x     <= 34'(CORDIC_GAIN);
          y     <= '0;
          k     <= '0;
          state <= S_CORD;
        end
        S_CORD: begin
          if (z >= 0) begin
            x <= x - ysh;
            y <= y + xsh;
            z <= z - at;
          end else begin
            x <= x + ysh;
            y <= y - xsh;
            z <= z + at;
          end
          k <= k + 1'b1;
          if (k == KW'(CORDIC_STEPS - 1)) begin
            state <= S_CBIN;
          end
        end
        S_CBIN: begin
          if (cz || x <= 0) begin
            cb <= '0;
          end else if (32'(cbv) > 32'(COS_BINS - 1)) begin
            cb <= CBW'(COS_BINS - 1);
          end else begin
            cb <= CBW'(cbv);
          end
          state <= S_EROW;
        end
        S_EROW: begin
          erow  <= AWE'(cb * DEPTH_BINS + db);
          state <= S_EBASE;
        end
        S_EBASE: begin
          ea       <= AWE'(erow * ENERGY_BINS);
          ej       <= '0;
          ed_valid <= 1'b0;
          state    <= S_ESCAN;
        end
        S_ESCAN: begin
          ed_valid <= 1'b1;
          ed_j     <= ej;
          if (ej != JW'(ENERGY_BINS - 1)) begin
            ej <= ej + 1'b1;
            ea <= ea + 1'b1;
          end
          if (en_hit) begin
            jf    <= ed_j;
            state <= S_LOG1;
          end
        end
        S_LOG1: begin
          u     <= UW'({jf, 14'b0}) + UW'(cur.rand_log[31:18]) + UW'(4096);
          state <= S_LOG2;
        end
        S_LOG2: begin
          qe    <= p5[UW+23:26];
          state <= S_LOG3;
        end
        S_LOG3: begin
          ru    <= u - UW'(qe * 5);
          state <= S_LOG4;
        end
        S_LOG4: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      out_theta <= theta[23:0];
      out_phi   <= phi[25:0];
      out_mwe   <= mwe;
      out_lg    <= lg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rvalid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      rvalid <= 1'b1;
    end else if (result.ready) begin
      rvalid <= 1'b0;
    end
  end

  assign result.valid      = rvalid;
  assign result.theta_deg  = out_theta;
  assign result.phi_deg    = out_phi;
  assign result.depth_mwe  = out_mwe;
  assign result.log_energy = $signed(out_lg);

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> state == S_IDLE)
    else $error("queue popped while a sample is in progress");

  a_ang_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ASCAN |-> a <= AWA'(LAST))
    else $error("angular scan index ran past the last entry");

  a_en_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_ESCAN |-> ej <= JW'(ENERGY_BINS - 1))
    else $error("energy scan index ran past the last entry");

  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(rvalid) |-> $past(state) == S_OUT)
    else $error("result word raised outside the output step");

endmodule
`default_nettype wire

FILE: hdl/cdf_table_angle_energy_sampler_unit.sv
// Top level of the angle, depth and energy sampler with its register port.
`default_nettype none
// Table write words are performed as they are popped from the head of the
// four-word input queue while the back end is idle. A sample word scans the
// angular CDF and then the energy CDF, each scan reading one entry per cycle
// from its table RAM up to the entry found; the cosine comes from an iterative
// CORDIC, and depth and log steps run through DREAD to DFIX and LOG1 to LOG4.
// The tables are not cleared after reset and must be loaded before sampling.
// The queue takes words while a sample runs or a result waits, until full.
module cdf_table_angle_energy_sampler_unit import cats_pkg::*; #(
  parameter int ZENITH_BINS  = ZENITH_BINS_DEF,
  parameter int AZIMUTH_BINS = AZIMUTH_BINS_DEF,
  parameter int ENERGY_BINS  = ENERGY_BINS_DEF,
  parameter int DEPTH_BINS   = DEPTH_BINS_DEF,
  parameter int COS_BINS     = COS_BINS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  cats_item_if.sink        item,
  cats_result_if.source    result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t  cfg;
  head_t head;
  logic  pop;
  logic  wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.theta_start        <= '0;
      cfg.phi_start          <= '0;
      cfg.rock_density_centi <= ROCK_DENS_RESET;
    end else if (wr) begin
      case (paddr[3:2])
        REG_THETA_START: cfg.theta_start        <= pwdata[6:0];
        REG_PHI_START:   cfg.phi_start          <= pwdata[8:0];
        REG_ROCK_DENS:   cfg.rock_density_centi <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THETA_START: prdata = 32'(cfg.theta_start);
      REG_PHI_START:   prdata = 32'(cfg.phi_start);
      REG_ROCK_DENS:   prdata = 32'(cfg.rock_density_centi);
      default:         prdata = '0;
    endcase
  end

  cats_front #(
    .ZENITH_BINS (ZENITH_BINS),
    .AZIMUTH_BINS(AZIMUTH_BINS),
    .ENERGY_BINS (ENERGY_BINS),
    .DEPTH_BINS  (DEPTH_BINS),
    .COS_BINS    (COS_BINS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .head (head),
    .pop  (pop)
  );

  cats_back #(
    .ZENITH_BINS (ZENITH_BINS),
    .AZIMUTH_BINS(AZIMUTH_BINS),
    .ENERGY_BINS (ENERGY_BINS),
    .DEPTH_BINS  (DEPTH_BINS),
    .COS_BINS    (COS_BINS)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .head   (head),
    .pop    (pop),
    .result (result)
  );

endmodule
`default_nettype wire

FILE: tb/cdf_table_angle_energy_sampler_unit_tb.sv
// Self-checking testbench of the angle, depth and energy sampler with table and register traffic.
`default_nettype none
module cdf_table_angle_energy_sampler_unit_tb;
  import cats_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int AZ       = AZIMUTH_BINS_DEF;
  localparam int LAST     = ZENITH_BINS_DEF * AZIMUTH_BINS_DEF;
  localparam int ANGLE_N  = LAST + 1;
  localparam int DEPTH_N  = (ZENITH_BINS_DEF + 1) * AZIMUTH_BINS_DEF;
  localparam int ENERGY_N = COS_BINS_DEF * DEPTH_BINS_DEF * ENERGY_BINS_DEF;
  localparam int IDLE_LIMIT = 100000;
  localparam int NPH = 13;
  localparam longint ATAN_Q16 [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
                                       58666, 29334, 14668, 7334, 3667, 1833, 917, 458,
                                       229, 115};

  typedef struct {
    op_t         op;
    logic [18:0] idx;
    logic [31:0] val;
    logic [31:0] rb;
    logic [31:0] rt;
    logic [31:0] rp;
    logic [31:0] re;
    logic [31:0] rl;
  } item_t;

  typedef struct {
    logic [23:0] theta;
    logic [25:0] phi;
    logic [14:0] depth;
    logic [19:0] loge;
  } res_t;

  class sampler_sb;
    bit [31:0] acdf [ANGLE_N];
    bit        acdf_ok [ANGLE_N];
    bit [15:0] dmap [DEPTH_N];
    bit        dmap_ok [DEPTH_N];
    bit [31:0] ecdf [ENERGY_N];
    bit        ecdf_ok [ENERGY_N];
    bit [6:0]  theta_start;
    bit [8:0]  phi_start;
    bit [8:0]  density;
    res_t      pending [$];
    int        errors;

    function new();
      density = ROCK_DENS_RESET;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_reg(logic [1:0] r, logic [31:0] v);
      if (r == REG_THETA_START) theta_start = v[6:0];
      else if (r == REG_PHI_START) phi_start = v[8:0];
      else if (r == REG_ROCK_DENS) density = v[8:0];
    endfunction

    function int unsigned cos_bin(longint unsigned t);
      longint x, y, z, nx;
      longint unsigned b;
      t = t % (360 * DEG_Q16);
      if (t > 180 * DEG_Q16) t = 360 * DEG_Q16 - t;
      if (t >= 90 * DEG_Q16) return 0;
      x = CORDIC_GAIN;
      y = 0;
      z = longint'(t);
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        if (z >= 0) begin
          nx = x - (y >>> k);
          y = y + (x >>> k);
          z -= ATAN_Q16[k];
        end else begin
          nx = x + (y >>> k);
          y = y - (x >>> k);
          z += ATAN_Q16[k];
        end
        x = nx;
      end
      if (x <= 0) return 0;
      b = ($unsigned(x) * 64'(COS_BINS_DEF - 1)) >> 30;
      if (b > COS_BINS_DEF - 1) b = COS_BINS_DEF - 1;
      return b[31:0];
    endfunction

    // Returns 0 with the first unwritten entry the sample would read.
    function bit sample(item_t w, output res_t r, output op_t miss_op, output int miss_idx);
      int i, j, bin_idx, tb, pb, db, cb, didx, ebase;
      longint unsigned theta, phi, prod, mwe, q;
      longint num, lg;
      miss_op = OP_SAMPLE;
      miss_idx = 0;
      r = '{default: 0};
      i = 1;
      forever begin
        if (!acdf_ok[i]) begin
          miss_op = OP_WR_ANGLE;
          miss_idx = i;
          return 0;
        end
        if (i == LAST || w.rb <= acdf[i]) break;
        i++;
      end
      bin_idx = i - 1;
      tb = bin_idx / AZ;
      pb = bin_idx % AZ;
      theta = (64'(theta_start) + 64'(tb)) * 65536 + 64'(w.rt[31:16]);
      phi = (64'(phi_start) + 64'(pb)) * 65536 + 64'(w.rp[31:16]);
      didx = tb * AZ + pb;
      if (!dmap_ok[didx]) begin
        miss_op = OP_WR_DEPTH;
        miss_idx = didx;
        return 0;
      end
      prod = 64'(dmap[didx]) * 64'(density);
      mwe = prod / 1000;
      if (mwe > 32767) mwe = 32767;
      q = prod / 200000;
      if (q < 16) db = 0;
      else if (q - 16 > DEPTH_BINS_DEF - 1) db = DEPTH_BINS_DEF - 1;
      else db = int'(q - 16);
      cb = int'(cos_bin(theta));
      ebase = (cb * DEPTH_BINS_DEF + db) * ENERGY_BINS_DEF;
      j = 0;
      forever begin
        if (!ecdf_ok[ebase + j]) begin
          miss_op = OP_WR_ENERGY;
          miss_idx = ebase + j;
          return 0;
        end
        if (j == ENERGY_BINS_DEF - 1 || w.re <= ecdf[ebase + j]) break;
        j++;
      end
      num = (longint'(j) - 1) * 64'sd4294967296 + longint'({32'b0, w.rl});
      if (num >= 0) lg = num / 1310720;
      else lg = -((-num + 1310719) / 1310720);
      r.theta = theta[23:0];
      r.phi = phi[25:0];
      r.depth = mwe[14:0];
      r.loge = lg[19:0];
      return 1;
    endfunction

    task note_input(item_t w);
      res_t r;
      op_t mop;
      int midx;
      case (w.op)
        OP_WR_ANGLE: if (w.idx < ANGLE_N) begin
          acdf[w.idx] = w.val;
          acdf_ok[w.idx] = 1;
        end
        OP_WR_DEPTH: if (w.idx < DEPTH_N) begin
          dmap[w.idx] = w.val[15:0];
          dmap_ok[w.idx] = 1;
        end
        OP_WR_ENERGY: if (w.idx < ENERGY_N) begin
          ecdf[w.idx] = w.val;
          ecdf_ok[w.idx] = 1;
        end
        default: begin
          if (!sample(w, r, mop, midx)) report("sample reads an unwritten entry");
          pending.push_back(r);
        end
      endcase
    endtask

    task check_result(res_t got);
      res_t exp;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      exp = pending.pop_front();
      if (got.theta !== exp.theta)
        report($sformatf("theta_deg %0h, expected %0h", got.theta, exp.theta));
      if (got.phi !== exp.phi)
        report($sformatf("phi_deg %0h, expected %0h", got.phi, exp.phi));
      if (got.depth !== exp.depth)
        report($sformatf("depth_mwe %0d, expected %0d", got.depth, exp.depth));
      if (got.loge !== exp.loge)
        report($sformatf("log_energy %0h, expected %0h", got.loge, exp.loge));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  cats_item_if item_ch();
  cats_result_if res_ch();

  cdf_table_angle_energy_sampler_unit u_dut (
    .clk(clk), .rst(rst), .item(item_ch), .result(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  sampler_sb sb = new();
  int n_sent;
  int n_results;
  int stop_pct = 30;
  int burst_left;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) burst_left = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic item_t rand_item();
    item_t w;
    w.op = op_t'($urandom_range(0, 3));
    w.idx = 19'($urandom);
    w.val = $urandom;
    w.rb = $urandom;
    w.rt = $urandom;
    w.rp = $urandom;
    w.re = $urandom;
    w.rl = $urandom;
    return w;
  endfunction

  function automatic item_t rand_write();
    item_t w;
    int sz;
    w = rand_item();
    w.op = op_t'($urandom_range(1, 3));
    sz = (w.op == OP_WR_ANGLE) ? ANGLE_N : (w.op == OP_WR_DEPTH) ? DEPTH_N : ENERGY_N;
    if ($urandom_range(0, 9) == 0) w.idx = 19'($urandom_range(sz, 19'h7FFFF));
    else w.idx = 19'($urandom_range(0, sz - 1));
    return w;
  endfunction

  function automatic item_t rand_sample();
    item_t w;
    int r;
    w = rand_item();
    w.op = OP_SAMPLE;
    r = $urandom_range(0, 19);
    if (r == 0) w.rb = 0;
    else if (r == 1) w.rb = '1;
    r = $urandom_range(0, 19);
    if (r == 0) w.re = 0;
    else if (r == 1) w.re = '1;
    return w;
  endfunction

  task automatic send(item_t w);
    int gap;
    item_ch.valid <= 1;
    item_ch.req_type <= w.op;
    item_ch.table_index <= w.idx;
    item_ch.table_value <= w.val;
    item_ch.rand_bin <= w.rb;
    item_ch.rand_theta <= w.rt;
    item_ch.rand_phi <= w.rp;
    item_ch.rand_energy <= w.re;
    item_ch.rand_log <= w.rl;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_input(w);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Loads every entry the sample would read before the sample word itself.
  task automatic send_sample(item_t s);
    item_t w;
    res_t r;
    op_t mop;
    int midx, k;
    while (!sb.sample(s, r, mop, midx)) begin
      w = rand_item();
      w.op = mop;
      w.idx = 19'(midx);
      k = $urandom_range(0, 99);
      if (mop == OP_WR_DEPTH) begin
        if (k < 10) w.val[15:0] = 16'hFFFF;
        else if (k < 20) w.val[15:0] = 0;
      end else if (k < stop_pct) begin
        w.val = '1;
      end
      send(w);
    end
    send(s);
  endtask

  task automatic drain();
    item_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic reg_write(logic [1:0] r, logic [31:0] v);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {r, 2'b00};
    pwdata <= v;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0;
    penable <= 0;
    @(posedge clk);
    sb.set_reg(r, v);
  endtask

  task automatic set_regs(int ts, int ps, int dn);
    reg_write(REG_THETA_START, {$urandom} & ~32'h7F | ts);
    reg_write(REG_PHI_START, {$urandom} & ~32'h1FF | ps);
    reg_write(REG_ROCK_DENS, {$urandom} & ~32'h1FF | dn);
  endtask

  task automatic directed();
    item_t s;
    s = rand_sample();
    s.rb = 0;
    s.re = 0;
    s.rt = 0;
    s.rp = 0;
    s.rl = 0;
    send_sample(s);
    s = rand_sample();
    s.rb = 0;
    s.re = '1;
    s.rt = '1;
    s.rp = '1;
    s.rl = '1;
    stop_pct = 0;
    send_sample(s);
    stop_pct = 30;
    for (int k = 1; k <= 3; k++) begin
      s = rand_item();
      s.op = op_t'(k);
      s.idx = 19'((k == 1) ? ANGLE_N : (k == 2) ? DEPTH_N : ENERGY_N);
      send(s);
      s.idx = 19'h7FFFF;
      send(s);
    end
    s = rand_item();
    s.op = OP_WR_ANGLE;
    s.idx = 0;
    send(s);
    s = rand_sample();
    s.rb = '1;
    send_sample(s);
    s = rand_sample();
    s.re = 1;
    send_sample(s);
    for (int k = 0; k < 6; k++) send_sample(rand_sample());
  endtask

  task automatic random_items(int n);
    int start;
    start = n_sent;
    while (n_sent - start < n) begin
      if ($urandom_range(0, 99) < 70) send_sample(rand_sample());
      else send(rand_write());
    end
  endtask

  initial begin
    int ts_set [6] = '{0, 127, 89, 0, 64, 1};
    int ps_set [6] = '{0, 511, 359, 0, 180, 1};
    int dn_set [6] = '{270, 511, 100, 0, 400, 1};
    item_ch.valid <= 0;
    item_ch.req_type <= OP_SAMPLE;
    item_ch.table_index <= 0;
    item_ch.table_value <= 0;
    item_ch.rand_bin <= 0;
    item_ch.rand_theta <= 0;
    item_ch.rand_phi <= 0;
    item_ch.rand_energy <= 0;
    item_ch.rand_log <= 0;
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
    paddr <= 0;
    pwdata <= 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    directed();
    for (int ph = 0; ph < NPH; ph++) begin
      drain();
      if (ph < 6) set_regs(ts_set[ph], ps_set[ph], dn_set[ph]);
      else set_regs($urandom_range(0, 127), $urandom_range(0, 511), $urandom_range(0, 511));
      random_items(145);
    end
    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    int stall_left, hold_left;
    bit held;
    res_t got;
    res_ch.ready <= 0;
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        got.theta = res_ch.theta_deg;
        got.phi = res_ch.phi_deg;
        got.depth = res_ch.depth_mwe;
        got.loge = res_ch.log_energy;
        sb.check_result(got);
        n_results++;
      end
      if (!held && n_results == 300) begin
        held = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 0;
      end else if (stall_left > 0) begin
        stall_left--;
        res_ch.ready <= 0;
      end else begin
        res_ch.ready <= 1;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    int idle_cycles;
    forever begin
      @(posedge clk);
      if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end
endmodule
`default_nettype wire
